@@ rtl/gst_pkg.sv @@
// Shared types, widths and codes for the generational slot table.
package gst_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int INDEX_BITS = 5;
  localparam int GEN_W      = 16;
  localparam int HANDLE_W   = GEN_W + INDEX_BITS;
  localparam int TAG_W      = 8;
  localparam int CREATOR_W  = 16;
  localparam int MEMBER_W   = 8;
  localparam int DOM_W      = 4;
  localparam int HOLD_W     = 5;

  localparam logic [HOLD_W-1:0]   HOLD_MAX   = '1;
  localparam logic [MEMBER_W-1:0] MEMBER_MAX = '1;

  typedef enum logic [3:0] {
    OP_ALLOC_IMPLICIT = 4'd0,
    OP_ALLOC_CREATOR  = 4'd1,
    OP_RESOLVE        = 4'd2,
    OP_MAKE_HANDLE    = 4'd3,
    OP_CHECK_CREATOR  = 4'd4,
    OP_ORPHAN         = 4'd5,
    OP_DROP_HOLD      = 4'd6,
    OP_ADD_MEMBER     = 4'd7,
    OP_RELEASE        = 4'd8,
    OP_QUERY          = 4'd9
  } gst_op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_DENIED    = 2'd3;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_TAKE    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef struct packed {
    logic [3:0]           opcode;
    logic [SLOT_W-1:0]    slot;
    logic [CREATOR_W-1:0] creator;
    logic [HANDLE_W-1:0]  handle_in;
    logic                 grant_ok;
    logic [DOM_W-1:0]     grant_domain;
  } gst_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                found;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [MEMBER_W-1:0] members;
    logic [DOM_W-1:0]    domain_out;
    logic                domain_present;
    logic [1:0]          domain_action;
    logic                last;
  } gst_res_t;

  typedef struct packed {
    logic [GEN_W-1:0]    generation;
    logic [MEMBER_W-1:0] member_count;
    logic [TAG_W-1:0]    creator_byte;
    logic [DOM_W-1:0]    slot_domain;
    logic                domain_valid;
  } slot_ent_t;

  localparam int ENT_W = $bits(slot_ent_t);

endpackage

@@ rtl/gst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/generational_slot_table_core.sv @@
// Generational slot table: slot state in one RAM, read-modify-write sequencer.
// A request is taken only in the idle state, which issues its RAM read; the execute state
//   uses the registered read data and loads the result into the output register. Allocate
//   scans one slot a cycle from slot 0 until it finds a free slot or reaches the last;
//   orphan scans all 16 slots (none with no holds or a zero tag), then flush emits its result.
//   No new request is taken until the last is done; an output stall can hold the block.
// Reset: synchronous, active low; per-slot valid flops make every slot read as zero.
module generational_slot_table_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gst_pkg::gst_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output gst_pkg::gst_res_t out_res
);
  import gst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  gst_req_t            req_r, req_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  gst_res_t            pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                out_valid_r;
  gst_res_t            out_res_r;
  logic [SLOTS-1:0]    slot_vld_r;
  logic                rd_vld_r;

  logic                accept;
  logic                out_free;
  logic                emit;
  gst_res_t            emit_res;
  logic                wr_en;
  slot_ent_t           wr_data;
  logic [SLOT_W-1:0]   rd_addr;
  logic [ENT_W-1:0]    rd_raw;
  slot_ent_t           ent;
  logic [SLOT_W-1:0]   start_idx;
  logic [TAG_W-1:0]    tag;
  logic                last_slot;

  slot_ent_t           alloc_ent, add_ent, rel_ent, drop_ent;
  gst_res_t            rel_res, drop_res;
  logic                held;
  logic                hit;
  logic [INDEX_BITS-1:0] biased;
  logic [HOLD_W-1:0]   hold_dec;

  function automatic logic [HANDLE_W-1:0] handle_of(input logic [SLOT_W-1:0] idx,
                                                    input logic [GEN_W-1:0] gen);
    handle_of = {gen, INDEX_BITS'(idx) + INDEX_BITS'(1)};
  endfunction

  function automatic gst_res_t fill_slot(input logic [SLOT_W-1:0] idx, input slot_ent_t e);
    gst_res_t r;
    r                = '0;
    r.slot_out       = idx;
    r.handle_out     = handle_of(idx, e.generation);
    r.members        = e.member_count;
    r.domain_present = e.domain_valid;
    r.domain_out     = e.domain_valid ? e.slot_domain : '0;
    return r;
  endfunction

  gst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign ent       = rd_vld_r ? slot_ent_t'(rd_raw) : '0;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign tag       = req_r.creator[TAG_W-1:0];
  assign last_slot = (cur_r == SLOT_W'(SLOTS - 1));
  assign biased    = req_r.handle_in[INDEX_BITS-1:0];
  assign hold_dec  = (hold_r != '0) ? hold_r - HOLD_W'(1) : hold_r;
  assign held      = (ent.creator_byte != '0);
  assign hit       = (biased != '0) && (biased <= INDEX_BITS'(SLOTS))
                     && (ent.generation == req_r.handle_in[HANDLE_W-1:INDEX_BITS])
                     && held;

  always_comb begin
    priority case (in_req.opcode)
      OP_ALLOC_IMPLICIT, OP_ALLOC_CREATOR, OP_ORPHAN: start_idx = '0;
      OP_RESOLVE: start_idx = SLOT_W'(in_req.handle_in[INDEX_BITS-1:0] - INDEX_BITS'(1));
      default:    start_idx = in_req.slot;
    endcase
  end

  always_comb begin
    alloc_ent              = ent;
    alloc_ent.member_count = '0;
    alloc_ent.creator_byte = (req_r.opcode == OP_ALLOC_CREATOR) ? tag : '0;
    alloc_ent.slot_domain  = req_r.grant_domain;
    alloc_ent.domain_valid = 1'b1;

    add_ent = ent;
    if (ent.member_count != MEMBER_MAX) begin
      add_ent.member_count = ent.member_count + MEMBER_W'(1);
    end

    rel_ent = ent;
    if (ent.member_count != '0) begin
      rel_ent.member_count = ent.member_count - MEMBER_W'(1);
    end
    if (ent.member_count == MEMBER_W'(1) && !held) begin
      rel_ent.slot_domain  = '0;
      rel_ent.domain_valid = 1'b0;
      rel_ent.generation   = ent.generation + GEN_W'(1);
    end
    rel_res               = fill_slot(cur_r, rel_ent);
    rel_res.found         = (ent.member_count == MEMBER_W'(1));
    rel_res.domain_action = (ent.member_count == MEMBER_W'(1) && ent.domain_valid)
                            ? ACT_RELEASE : ACT_NONE;
    rel_res.domain_out    = ent.domain_valid ? ent.slot_domain : '0;

    drop_ent              = ent;
    drop_ent.creator_byte = '0;
    if (ent.member_count == '0) begin
      drop_ent.slot_domain  = '0;
      drop_ent.domain_valid = 1'b0;
      drop_ent.generation   = ent.generation + GEN_W'(1);
    end
    drop_res          = '0;
    drop_res.slot_out = cur_r;
    if (held) begin
      drop_res               = fill_slot(cur_r, drop_ent);
      drop_res.found         = (ent.member_count == '0);
      drop_res.domain_action = ent.domain_valid ? ACT_RELEASE : ACT_NONE;
      drop_res.domain_out    = ent.domain_valid ? ent.slot_domain : '0;
    end
  end

  always_comb begin
    gst_res_t  res_c;
    slot_ent_t wdat_c;
    logic      wr_c;
    logic      done_c;
    logic      adv_c;
    logic [HOLD_W-1:0] hold_c;

    state_nxt    = state_r;
    req_nxt      = req_r;
    cur_nxt      = cur_r;
    hold_nxt     = hold_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    emit         = 1'b0;
    emit_res     = '0;
    wr_en        = 1'b0;
    wr_data      = ent;
    rd_addr      = cur_r;
    res_c        = '0;
    wdat_c       = ent;
    wr_c         = 1'b0;
    done_c       = 1'b0;
    adv_c        = 1'b0;
    hold_c       = hold_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_req;
          pend_vld_nxt = 1'b0;
          cur_nxt      = start_idx;
          rd_addr      = start_idx;
          if (in_req.opcode == OP_ORPHAN
              && (hold_r == '0 || in_req.creator[TAG_W-1:0] == '0)) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (req_r.opcode == OP_ORPHAN) begin
          if (ent.creator_byte == tag) begin
            if (!pend_vld_r || out_free) begin
              if (pend_vld_r) begin
                emit     = 1'b1;
                emit_res = pend_r;
              end
              pend_nxt     = drop_res;
              pend_vld_nxt = 1'b1;
              wr_en        = 1'b1;
              wr_data      = drop_ent;
              hold_nxt     = hold_dec;
              adv_c        = 1'b1;
            end
          end else begin
            adv_c = 1'b1;
          end
          if (adv_c) begin
            if (last_slot) begin
              state_nxt = S_FLUSH;
            end else begin
              cur_nxt = cur_r + SLOT_W'(1);
              rd_addr = cur_r + SLOT_W'(1);
            end
          end
        end else begin
          priority case (req_r.opcode)
            OP_ALLOC_IMPLICIT, OP_ALLOC_CREATOR: begin
              if (req_r.opcode == OP_ALLOC_CREATOR && tag == '0) begin
                res_c.status = ST_DENIED;
                done_c       = 1'b1;
              end else if (!req_r.grant_ok) begin
                res_c.status = ST_REFUSED;
                done_c       = 1'b1;
              end else if (ent.member_count == '0 && !held) begin
                res_c  = fill_slot(cur_r, alloc_ent);
                wdat_c = alloc_ent;
                wr_c   = 1'b1;
                done_c = 1'b1;
                if (req_r.opcode == OP_ALLOC_CREATOR) begin
                  res_c.domain_action = ACT_TAKE;
                  if (hold_r != HOLD_MAX) begin
                    hold_c = hold_r + HOLD_W'(1);
                  end
                end
              end else if (last_slot) begin
                res_c.status = ST_EXHAUSTED;
                done_c       = 1'b1;
              end else begin
                adv_c = 1'b1;
              end
            end
            OP_RESOLVE: begin
              done_c = 1'b1;
              if (hit) begin
                res_c       = fill_slot(cur_r, ent);
                res_c.found = 1'b1;
              end
            end
            OP_MAKE_HANDLE: begin
              done_c = 1'b1;
              res_c  = fill_slot(cur_r, ent);
            end
            OP_CHECK_CREATOR: begin
              done_c      = 1'b1;
              res_c       = fill_slot(cur_r, ent);
              res_c.found = (tag != '0) && (ent.creator_byte == tag);
            end
            OP_DROP_HOLD: begin
              done_c = 1'b1;
              res_c  = drop_res;
              wdat_c = drop_ent;
              wr_c   = held;
              if (held) begin
                hold_c = hold_dec;
              end
            end
            OP_ADD_MEMBER: begin
              done_c = 1'b1;
              res_c  = fill_slot(cur_r, add_ent);
              wdat_c = add_ent;
              wr_c   = 1'b1;
              if (ent.member_count == '0 && ent.domain_valid) begin
                res_c.domain_action = ACT_TAKE;
              end
            end
            OP_RELEASE: begin
              done_c = 1'b1;
              res_c  = rel_res;
              wdat_c = rel_ent;
              wr_c   = 1'b1;
            end
            OP_QUERY: begin
              done_c      = 1'b1;
              res_c       = fill_slot(cur_r, ent);
              res_c.found = (ent.member_count != '0) || held;
            end
            default: begin
              res_c.status = ST_DENIED;
              done_c       = 1'b1;
            end
          endcase

          if (done_c && out_free) begin
            emit          = 1'b1;
            emit_res      = res_c;
            emit_res.last = 1'b1;
            wr_en         = wr_c;
            wr_data       = wdat_c;
            hold_nxt      = hold_c;
            state_nxt     = S_IDLE;
          end else if (adv_c) begin
            cur_nxt = cur_r + SLOT_W'(1);
            rd_addr = cur_r + SLOT_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res      = pend_vld_r ? pend_r : '0;
          emit_res.last = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      hold_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      slot_vld_r  <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      hold_r     <= hold_nxt;
      pend_vld_r <= pend_vld_nxt;
      rd_vld_r   <= slot_vld_r[rd_addr];
      if (wr_en) begin
        slot_vld_r[cur_r] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_EXEC))
    else $error("slot RAM written outside the execute state");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a stalled output");

  a_pend_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (req_r.opcode == OP_ORPHAN))
    else $error("pending result held outside an orphan request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request taken without entering the execute path");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for generational_slot_table_core with a shadow model of the slot pool.
`timescale 1ns / 100ps

module testbench;
  import gst_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_ITEMS    = 16;
  localparam int MAX_DROPS       = 16;
  localparam int REPORT_CAP      = 100;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  gst_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  gst_res_t out_res;

  logic [GEN_W-1:0]    gen_shadow       [SLOTS];
  logic [MEMBER_W-1:0] members_shadow   [SLOTS];
  logic [TAG_W-1:0]    tag_shadow       [SLOTS];
  logic [DOM_W-1:0]    dom_shadow       [SLOTS];
  logic                dom_valid_shadow [SLOTS];
  logic [HOLD_W-1:0]   holds_shadow;

  gst_res_t pending_results[$];
  int       mismatch_count;
  int       results_checked;
  int       burst_left;
  int       hold_off_cycles;

  generational_slot_table_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) begin
      $display("mismatch at result %0d: %s", results_checked, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  function automatic gst_res_t slot_view(input int s);
    gst_res_t r;
    r = '0;
    r.slot_out       = SLOT_W'(s);
    r.handle_out     = {gen_shadow[s], INDEX_BITS'(s + 1)};
    r.members        = members_shadow[s];
    r.domain_present = dom_valid_shadow[s];
    if (dom_valid_shadow[s]) begin
      r.domain_out = dom_shadow[s];
    end
    return r;
  endfunction

  function automatic void retire_slot(input int s, inout gst_res_t r);
    if (dom_valid_shadow[s]) begin
      r.domain_action = ACT_RELEASE;
      r.domain_out    = dom_shadow[s];
    end
    dom_shadow[s]       = '0;
    dom_valid_shadow[s] = 1'b0;
    tag_shadow[s]       = '0;
    gen_shadow[s]       = gen_shadow[s] + 1'b1;
  endfunction

  function automatic gst_res_t drop_hold_of(input int s);
    gst_res_t r;
    r = '0;
    r.slot_out = SLOT_W'(s);
    if (tag_shadow[s] != '0) begin
      tag_shadow[s] = '0;
      if (holds_shadow != '0) begin
        holds_shadow--;
      end
      if (members_shadow[s] == '0) begin
        retire_slot(s, r);
        r.found = 1'b1;
      end else if (dom_valid_shadow[s]) begin
        r.domain_action = ACT_RELEASE;
        r.domain_out    = dom_shadow[s];
      end
      r.handle_out     = {gen_shadow[s], INDEX_BITS'(s + 1)};
      r.members        = members_shadow[s];
      r.domain_present = dom_valid_shadow[s];
    end
    return r;
  endfunction

  task automatic predict_slot_table(input gst_req_t req);
    gst_res_t              r;
    gst_res_t              outs[$];
    logic [TAG_W-1:0]      tag;
    logic [INDEX_BITS-1:0] biased;
    logic [1:0]            act;
    logic [DOM_W-1:0]      rel_dom;
    logic                  emptied;
    int                    s;
    int                    f;
    int                    i;
    r   = '0;
    s   = req.slot;
    tag = req.creator[TAG_W-1:0];
    case (req.opcode)
      OP_ALLOC_IMPLICIT, OP_ALLOC_CREATOR: begin
        f = -1;
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (members_shadow[i] == '0 && tag_shadow[i] == '0) f = i;
        end
        if (req.opcode == OP_ALLOC_CREATOR && tag == '0) begin
          r.status = ST_DENIED;
        end else if (!req.grant_ok) begin
          r.status = ST_REFUSED;
        end else if (f < 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          members_shadow[f]   = '0;
          dom_shadow[f]       = req.grant_domain;
          dom_valid_shadow[f] = 1'b1;
          tag_shadow[f]       = '0;
          if (req.opcode == OP_ALLOC_CREATOR) begin
            tag_shadow[f] = tag;
            if (holds_shadow != HOLD_MAX) holds_shadow++;
          end
          r = slot_view(f);
          if (req.opcode == OP_ALLOC_CREATOR) r.domain_action = ACT_TAKE;
        end
      end
      OP_RESOLVE: begin
        biased = req.handle_in[INDEX_BITS-1:0];
        if (biased != '0 && biased <= SLOTS) begin
          f = int'(biased) - 1;
          if (gen_shadow[f] == req.handle_in[HANDLE_W-1:INDEX_BITS] && tag_shadow[f] != '0) begin
            r       = slot_view(f);
            r.found = 1'b1;
          end
        end
      end
      OP_MAKE_HANDLE: begin
        r = slot_view(s);
      end
      OP_CHECK_CREATOR: begin
        r       = slot_view(s);
        r.found = (tag != '0 && tag_shadow[s] == tag);
      end
      OP_ORPHAN: begin
        if (holds_shadow != '0 && tag != '0) begin
          for (i = 0; i < SLOTS && outs.size() < MAX_DROPS; i++) begin
            if (tag_shadow[i] == tag) outs.push_back(drop_hold_of(i));
          end
        end
      end
      OP_DROP_HOLD: begin
        r = drop_hold_of(s);
      end
      OP_ADD_MEMBER: begin
        act = (members_shadow[s] == '0 && dom_valid_shadow[s]) ? ACT_TAKE : ACT_NONE;
        if (members_shadow[s] != MEMBER_MAX) members_shadow[s]++;
        r               = slot_view(s);
        r.domain_action = act;
      end
      OP_RELEASE: begin
        act     = ACT_NONE;
        rel_dom = '0;
        emptied = 1'b0;
        if (members_shadow[s] != '0) begin
          members_shadow[s]--;
          if (members_shadow[s] == '0) begin
            emptied = 1'b1;
            if (tag_shadow[s] != '0) begin
              if (dom_valid_shadow[s]) act = ACT_RELEASE;
            end else begin
              retire_slot(s, r);
              act     = r.domain_action;
              rel_dom = r.domain_out;
            end
          end
        end
        r               = slot_view(s);
        r.found         = emptied;
        r.domain_action = act;
        if (!dom_valid_shadow[s]) r.domain_out = rel_dom;
      end
      OP_QUERY: begin
        r       = slot_view(s);
        r.found = (members_shadow[s] != '0 || tag_shadow[s] != '0);
      end
      default: begin
        r.status = ST_DENIED;
      end
    endcase
    if (outs.size() == 0) outs.push_back(r);
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) pending_results.push_back(outs[k]);
  endtask

  function automatic gst_req_t mk_req(input logic [3:0] op, input int s,
                                      input logic [CREATOR_W-1:0] creator,
                                      input logic [HANDLE_W-1:0] handle,
                                      input logic grant, input logic [DOM_W-1:0] dom);
    gst_req_t req;
    req.opcode       = op;
    req.slot         = SLOT_W'(s);
    req.creator      = creator;
    req.handle_in    = handle;
    req.grant_ok     = grant;
    req.grant_domain = dom;
    return req;
  endfunction

  function automatic gst_req_t random_request();
    gst_req_t         req;
    int               used[$];
    int               pick;
    int               s;
    logic [TAG_W-1:0] tag;
    for (s = 0; s < SLOTS; s++) begin
      if (members_shadow[s] != '0 || tag_shadow[s] != '0) used.push_back(s);
    end
    if (used.size() != 0 && $urandom_range(0, 3) != 0) begin
      s = used[$urandom_range(0, used.size() - 1)];
    end else begin
      s = $urandom_range(0, SLOTS - 1);
    end
    case ($urandom_range(0, 6))
      0:       tag = 8'h01;
      1:       tag = 8'h80;
      2:       tag = 8'hFF;
      3, 4:    tag = tag_shadow[s];
      5:       tag = '0;
      default: tag = TAG_W'($urandom);
    endcase
    req.slot                 = SLOT_W'(s);
    req.creator              = CREATOR_W'($urandom);
    req.creator[TAG_W-1:0]   = tag;
    req.grant_ok             = ($urandom_range(0, 9) != 0);
    req.grant_domain         = DOM_W'($urandom);
    req.handle_in            = HANDLE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      req.opcode = ($urandom_range(0, 1) != 0) ? OP_ALLOC_CREATOR : OP_ALLOC_IMPLICIT;
    end else if (pick < 34) begin
      req.opcode = OP_RESOLVE;
      case ($urandom_range(0, 5))
        0, 1, 2: req.handle_in = {gen_shadow[s], INDEX_BITS'(s + 1)};
        3:       req.handle_in = {GEN_W'(gen_shadow[s] - 1'b1), INDEX_BITS'(s + 1)};
        4: begin
          if ($urandom_range(0, 1) != 0) begin
            req.handle_in[INDEX_BITS-1:0] = '0;
          end else begin
            req.handle_in[INDEX_BITS-1:0] =
              INDEX_BITS'($urandom_range(SLOTS + 1, (1 << INDEX_BITS) - 1));
          end
        end
        default: ;
      endcase
    end else if (pick < 39) begin
      req.opcode = OP_MAKE_HANDLE;
    end else if (pick < 45) begin
      req.opcode = OP_CHECK_CREATOR;
    end else if (pick < 51) begin
      req.opcode = OP_ORPHAN;
    end else if (pick < 57) begin
      req.opcode = OP_DROP_HOLD;
    end else if (pick < 72) begin
      req.opcode = OP_ADD_MEMBER;
    end else if (pick < 87) begin
      req.opcode = OP_RELEASE;
    end else if (pick < 96) begin
      req.opcode = OP_QUERY;
    end else begin
      req.opcode = 4'($urandom_range(int'(OP_QUERY) + 1, (1 << $bits(req.opcode)) - 1));
    end
    return req;
  endfunction

  task automatic send_request(input gst_req_t req);
    int gap;
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_slot_table(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_error_codes();
    send_request(mk_req(OP_QUERY, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_QUERY, SLOTS - 1, '1, '1, 1'b1, '1));
    send_request(mk_req(4'(int'(OP_QUERY) + 1), 0, '0, '0, 1'b0, '0));
    send_request(mk_req('1, SLOTS - 1, '1, '1, 1'b1, '1));
    send_request(mk_req(OP_RESOLVE, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_RESOLVE, 0, '0, '1, 1'b0, '0));
    send_request(mk_req(OP_ALLOC_IMPLICIT, 0, '0, '0, 1'b0, '1));
    send_request(mk_req(OP_ALLOC_CREATOR, 0, 16'hFF00, '0, 1'b1, '1));
    send_request(mk_req(OP_ORPHAN, 0, 16'h1200, '0, 1'b1, '0));
    send_request(mk_req(OP_ORPHAN, 0, 16'h0033, '0, 1'b1, '0));
  endtask

  task automatic test_alloc_and_lookup();
    send_request(mk_req(OP_ALLOC_CREATOR, 0, 16'hFFFF, '0, 1'b1, '1));
    send_request(mk_req(OP_ALLOC_IMPLICIT, 0, '0, '0, 1'b1, '0));
    send_request(mk_req(OP_MAKE_HANDLE, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_RESOLVE, 0, '0, {gen_shadow[0], INDEX_BITS'(1)}, 1'b0, '0));
    send_request(mk_req(OP_RESOLVE, 0, '0, {gen_shadow[1], INDEX_BITS'(2)}, 1'b0, '0));
    send_request(mk_req(OP_CHECK_CREATOR, 0, 16'h00FF, '0, 1'b0, '0));
    send_request(mk_req(OP_CHECK_CREATOR, 0, 16'h00FE, '0, 1'b0, '0));
    send_request(mk_req(OP_CHECK_CREATOR, 0, 16'h0000, '0, 1'b0, '0));
  endtask

  task automatic test_member_and_hold_lifecycle();
    logic [HANDLE_W-1:0] stale;
    send_request(mk_req(OP_ADD_MEMBER, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_ADD_MEMBER, 1, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_RELEASE, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_RELEASE, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_ADD_MEMBER, SLOTS - 1, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_RELEASE, SLOTS - 1, '0, '0, 1'b0, '0));
    stale = {gen_shadow[0], INDEX_BITS'(1)};
    send_request(mk_req(OP_DROP_HOLD, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_DROP_HOLD, 0, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_RESOLVE, 0, '0, stale, 1'b0, '0));
    send_request(mk_req(OP_RELEASE, 1, '0, '0, 1'b0, '0));
  endtask

  task automatic test_pool_exhaustion();
    logic [TAG_W-1:0]     tag;
    logic [CREATOR_W-1:0] creator;
    int                   s;
    int                   n;
    tag = TAG_W'($urandom_range(1, (1 << TAG_W) - 1));
    for (s = 0; s < SLOTS; s++) begin
      while (members_shadow[s] != '0) send_request(mk_req(OP_RELEASE, s, '0, '0, 1'b0, '0));
      if (tag_shadow[s] != '0) send_request(mk_req(OP_DROP_HOLD, s, '0, '0, 1'b0, '0));
    end
    for (n = 0; n < SLOTS + 2; n++) begin
      creator = CREATOR_W'($urandom);
      creator[TAG_W-1:0] = tag;
      send_request(mk_req((n == SLOTS) ? OP_ALLOC_IMPLICIT : OP_ALLOC_CREATOR, 0, creator,
                          HANDLE_W'($urandom), 1'b1, DOM_W'($urandom)));
    end
    repeat (3) begin
      send_request(mk_req(OP_ADD_MEMBER, $urandom_range(0, SLOTS - 1), '0, '0, 1'b0, '0));
    end
    creator = CREATOR_W'($urandom);
    creator[TAG_W-1:0] = tag;
    send_request(mk_req(OP_ORPHAN, 0, creator, '0, 1'b0, '0));
    wait_for_results();
  endtask

  task automatic test_output_hold_off();
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (12) send_request(random_request());
    wait_for_results();
  endtask

  task automatic test_member_saturation();
    int s;
    s = $urandom_range(0, SLOTS - 1);
    repeat (int'(MEMBER_MAX) + 2) begin
      send_request(mk_req(OP_ADD_MEMBER, s, '0, '0, 1'b0, '0));
    end
    send_request(mk_req(OP_RELEASE, s, '0, '0, 1'b0, '0));
    send_request(mk_req(OP_QUERY, s, '0, '0, 1'b0, '0));
  endtask

  task automatic test_random_traffic();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_request(random_request());
      if ($urandom_range(0, 59) == 0) wait_for_results();
    end
  endtask

  // receiver: segments of varying stall density, plus a long hold-off on request
  initial begin : rx_stall_pattern
    int seg_left;
    int stall_pct;
    seg_left  = 0;
    stall_pct = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    gst_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_res.status, want.status);
        check_field("found", out_res.found, want.found);
        check_field("slot_out", out_res.slot_out, want.slot_out);
        check_field("handle_out", out_res.handle_out, want.handle_out);
        check_field("members", out_res.members, want.members);
        check_field("domain_out", out_res.domain_out, want.domain_out);
        check_field("domain_present", out_res.domain_present, want.domain_present);
        check_field("domain_action", out_res.domain_action, want.domain_action);
        check_field("last", out_res.last, want.last);
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[generational_slot_table_core] ERROR");
    $finish;
  end

  initial begin : run_tests
    in_valid <= 1'b0;
    in_req   <= '0;
    rst_n    <= 1'b0;
    mismatch_count  = 0;
    results_checked = 0;
    burst_left      = 0;
    hold_off_cycles = 0;
    holds_shadow    = '0;
    foreach (gen_shadow[i]) begin
      gen_shadow[i]       = '0;
      members_shadow[i]   = '0;
      tag_shadow[i]       = '0;
      dom_shadow[i]       = '0;
      dom_valid_shadow[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_error_codes();
    test_alloc_and_lookup();
    test_member_and_hold_lifecycle();
    test_pool_exhaustion();
    test_output_hold_off();
    test_member_saturation();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("[generational_slot_table_core] OK");
    end else begin
      $display("[generational_slot_table_core] ERROR");
    end
    $finish;
  end

endmodule
